// ----- hw/rtl/mstr_pkg.sv -----
// Package of the multitouch slot tracker and re-encoder.
// Holds slot geometry, event codes, state codes and shared types.
// Used by mstr_ctrl and multitouch_slot_tracker_reencoder; depends on nothing.
`default_nettype none

package mstr_pkg;

  localparam int NUM_SLOTS   = 10;
  localparam int INJECT_SLOT = 9;
  localparam bit INJECT_OK   = INJECT_SLOT < NUM_SLOTS;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W       = $clog2(NUM_SLOTS + 1);

  localparam int ID_STRIDE    = 10;
  localparam int INJECT_TRACK = 19;
  localparam int DEV_MAX      = 4;

  localparam logic [4:0] T_SYN = 5'd0;
  localparam logic [4:0] T_KEY = 5'd1;
  localparam logic [4:0] T_ABS = 5'd3;

  localparam logic [9:0] C_SYN_FRAME       = 10'd0;
  localparam logic [9:0] C_SYN_MT_REPORT   = 10'd2;
  localparam logic [9:0] C_ABS_X           = 10'd0;
  localparam logic [9:0] C_ABS_Y           = 10'd1;
  localparam logic [9:0] C_MT_SLOT         = 10'd47;
  localparam logic [9:0] C_MT_X            = 10'd53;
  localparam logic [9:0] C_MT_Y            = 10'd54;
  localparam logic [9:0] C_MT_ID           = 10'd57;
  localparam logic [9:0] C_BTN_TOOL_FINGER = 10'd325;
  localparam logic [9:0] C_BTN_TOUCH       = 10'd330;

  localparam logic [31:0] LIFT_ID = 32'hFFFF_FFFF;

  localparam logic [0:0] CFG_READ_ONLY    = 1'd0;
  localparam logic [0:0] CFG_DEVICE_INDEX = 1'd1;

  typedef enum logic [1:0] {
    OP_RAW  = 2'd0,
    OP_DOWN = 2'd1,
    OP_UP   = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_HEAD,
    ST_SCAN,
    ST_FINGER,
    ST_TAIL,
    ST_END
  } state_e;

  typedef struct packed {
    logic       read_only;
    logic [2:0] dev_index;
  } cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  id;
  } slot_row_t;

  typedef struct packed {
    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
    logic               last;
  } event_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mstr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the per-slot rows of the tracker; depends on nothing.
`default_nettype none

module mstr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mstr_ctrl.sv -----
// Slot tracker control: item capture, read-modify-write of slot rows,
// report sequencer and output register. Depends on mstr_pkg and mstr_ram.
`default_nettype none

module mstr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mstr_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [4:0]          event_type_i,
  input  wire logic [9:0]          event_code_i,
  input  wire logic signed [31:0]  event_value_i,
  input  wire logic [15:0]         inject_x_i,
  input  wire logic [15:0]         inject_y_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output mstr_pkg::event_t         out_ev_o
);

  localparam int SlotW = mstr_pkg::SLOT_W;
  localparam int IdxW  = mstr_pkg::IDX_W;
  localparam logic [SlotW-1:0] InjAddr  = SlotW'(mstr_pkg::INJECT_SLOT);
  localparam logic [IdxW-1:0]  IdxEnd   = IdxW'(mstr_pkg::NUM_SLOTS);
  localparam logic [31:0]      SlotLim  = 32'(mstr_pkg::NUM_SLOTS);
  localparam logic [6:0]       IdBase   = 7'(mstr_pkg::ID_STRIDE);
  localparam logic [6:0]       IdStep   = 7'(2 * mstr_pkg::ID_STRIDE);
  localparam logic [6:0]       InjTrack = 7'(mstr_pkg::INJECT_TRACK);
  localparam logic [2:0]       DevMax   = 3'(mstr_pkg::DEV_MAX);

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v[31]) begin
      r = 16'd0;
    end else if (v[30:16] != 15'd0) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  mstr_pkg::state_e state_q, state_d;
  logic [2:0]       step_q, step_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  mstr_pkg::opcode_e  op_q;
  logic [4:0]         type_q;
  logic [9:0]         code_q;
  logic signed [31:0] value_q;
  logic [15:0]        ix_q, iy_q;

  logic [SlotW-1:0]     cur_slot_q, cur_slot_d;
  logic                 cur_ok_q, cur_ok_d;
  logic                 awaiting_q, awaiting_d;
  logic [mstr_pkg::NUM_SLOTS-1:0] down_q, row_valid_q;
  logic                 rvalid_q;

  logic                 ram_re, ram_we;
  logic [SlotW-1:0]     ram_raddr, ram_waddr;
  logic [$bits(mstr_pkg::slot_row_t)-1:0] ram_rdata;
  mstr_pkg::slot_row_t  row_rd, row_wr;

  logic                 down_set, down_clr;
  logic                 in_fire, emit, emit_ok;
  mstr_pkg::event_t     ev, out_q;
  logic                 out_valid_q;
  logic [2:0]           dev_c;
  logic [6:0]           tid;
  logic                 any_down;

  mstr_ram #(
    .Width($bits(mstr_pkg::slot_row_t)),
    .Depth(mstr_pkg::NUM_SLOTS),
    .AddrW(SlotW)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(row_wr)
  );

  assign in_stall_o = (state_q != mstr_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign emit_ok    = !out_valid_q || !out_stall_i;
  assign row_rd     = rvalid_q ? mstr_pkg::slot_row_t'(ram_rdata) : '0;
  assign dev_c      = (cfg_i.dev_index > DevMax) ? DevMax : cfg_i.dev_index;
  assign tid        = IdBase + 7'(7'(dev_c) * IdStep) + 7'(cur_slot_q);
  assign any_down   = |down_q;
  assign ram_waddr  = (op_q == mstr_pkg::OP_RAW) ? cur_slot_q : InjAddr;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    idx_d      = idx_q;
    cur_slot_d = cur_slot_q;
    cur_ok_d   = cur_ok_q;
    awaiting_d = awaiting_q;
    ram_re     = 1'b0;
    ram_raddr  = cur_slot_q;
    ram_we     = 1'b0;
    row_wr     = row_rd;
    down_set   = 1'b0;
    down_clr   = 1'b0;
    emit       = 1'b0;
    ev         = '0;

    case (state_q)
      mstr_pkg::ST_IDLE: begin
        if (in_fire) begin
          ram_re    = 1'b1;
          ram_raddr = (mstr_pkg::opcode_e'(opcode_i) == mstr_pkg::OP_RAW) ? cur_slot_q : InjAddr;
          state_d   = mstr_pkg::ST_UPD;
        end
      end

      mstr_pkg::ST_UPD: begin
        logic do_report;
        do_report = 1'b0;
        case (op_q)
          mstr_pkg::OP_RAW: begin
            if (type_q == mstr_pkg::T_ABS) begin
              case (code_q)
                mstr_pkg::C_MT_SLOT: begin
                  cur_slot_d = value_q[SlotW-1:0];
                  cur_ok_d   = 32'(value_q) < SlotLim;
                end
                mstr_pkg::C_MT_ID: begin
                  if (cur_ok_q) begin
                    if (32'(value_q) == mstr_pkg::LIFT_ID) begin
                      down_clr = 1'b1;
                    end else begin
                      down_set  = 1'b1;
                      row_wr.id = tid;
                      ram_we    = 1'b1;
                    end
                  end
                end
                mstr_pkg::C_MT_X: begin
                  if (cur_ok_q) begin
                    row_wr.id = tid;
                    row_wr.x  = sat16(value_q);
                    ram_we    = 1'b1;
                  end
                end
                mstr_pkg::C_MT_Y: begin
                  if (cur_ok_q) begin
                    row_wr.id = tid;
                    row_wr.y  = sat16(value_q);
                    ram_we    = 1'b1;
                  end
                end
                default: ;
              endcase
            end else if (type_q == mstr_pkg::T_SYN && code_q == mstr_pkg::C_SYN_FRAME) begin
              do_report = 1'b1;
            end
          end
          mstr_pkg::OP_DOWN: begin
            if (mstr_pkg::INJECT_OK) begin
              row_wr.x  = ix_q;
              row_wr.y  = iy_q;
              row_wr.id = InjTrack;
              ram_we    = 1'b1;
              down_set  = 1'b1;
            end
            do_report = 1'b1;
          end
          mstr_pkg::OP_UP: begin
            if (mstr_pkg::INJECT_OK) begin
              down_clr = 1'b1;
            end
            do_report = 1'b1;
          end
          default: ;
        endcase
        step_d  = 3'd0;
        idx_d   = '0;
        state_d = (do_report && !cfg_i.read_only) ? mstr_pkg::ST_HEAD : mstr_pkg::ST_IDLE;
      end

      mstr_pkg::ST_HEAD: begin
        if (any_down && awaiting_q) begin
          emit = 1'b1;
          ev.ev_type  = mstr_pkg::T_KEY;
          ev.ev_code  = (step_q == 3'd0) ? mstr_pkg::C_BTN_TOUCH : mstr_pkg::C_BTN_TOOL_FINGER;
          ev.ev_value = 32'sd1;
          if (emit_ok) begin
            if (step_q == 3'd1) begin
              awaiting_d = 1'b0;
              step_d     = 3'd0;
              state_d    = mstr_pkg::ST_SCAN;
            end else begin
              step_d = 3'd1;
            end
          end
        end else if (any_down) begin
          state_d = mstr_pkg::ST_SCAN;
        end else begin
          step_d  = 3'd0;
          state_d = mstr_pkg::ST_TAIL;
        end
      end

      mstr_pkg::ST_SCAN: begin
        ram_raddr = idx_q[SlotW-1:0];
        if (idx_q == IdxEnd) begin
          state_d = mstr_pkg::ST_END;
        end else if (down_q[idx_q[SlotW-1:0]]) begin
          ram_re  = 1'b1;
          step_d  = 3'd0;
          state_d = mstr_pkg::ST_FINGER;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      mstr_pkg::ST_FINGER: begin
        emit = 1'b1;
        ev.ev_type = mstr_pkg::T_ABS;
        case (step_q)
          3'd0: begin
            ev.ev_code  = mstr_pkg::C_ABS_X;
            ev.ev_value = {16'd0, row_rd.x};
          end
          3'd1: begin
            ev.ev_code  = mstr_pkg::C_ABS_Y;
            ev.ev_value = {16'd0, row_rd.y};
          end
          3'd2: begin
            ev.ev_code  = mstr_pkg::C_MT_X;
            ev.ev_value = {16'd0, row_rd.x};
          end
          3'd3: begin
            ev.ev_code  = mstr_pkg::C_MT_Y;
            ev.ev_value = {16'd0, row_rd.y};
          end
          3'd4: begin
            ev.ev_code  = mstr_pkg::C_MT_ID;
            ev.ev_value = {25'd0, row_rd.id};
          end
          default: begin
            ev.ev_type  = mstr_pkg::T_SYN;
            ev.ev_code  = mstr_pkg::C_SYN_MT_REPORT;
            ev.ev_value = 32'sd0;
          end
        endcase
        if (emit_ok) begin
          if (step_q == 3'd5) begin
            step_d  = 3'd0;
            idx_d   = idx_q + 1'b1;
            state_d = mstr_pkg::ST_SCAN;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end

      mstr_pkg::ST_TAIL: begin
        emit = 1'b1;
        case (step_q)
          3'd0: begin
            ev.ev_type = mstr_pkg::T_SYN;
            ev.ev_code = mstr_pkg::C_SYN_MT_REPORT;
          end
          3'd1: begin
            ev.ev_type = mstr_pkg::T_KEY;
            ev.ev_code = mstr_pkg::C_BTN_TOUCH;
          end
          default: begin
            ev.ev_type = mstr_pkg::T_KEY;
            ev.ev_code = mstr_pkg::C_BTN_TOOL_FINGER;
          end
        endcase
        if (emit_ok) begin
          if (step_q == 3'd0 && awaiting_q) begin
            state_d = mstr_pkg::ST_END;
          end else if (step_q == 3'd2) begin
            awaiting_d = 1'b1;
            state_d    = mstr_pkg::ST_END;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
      end

      mstr_pkg::ST_END: begin
        emit = 1'b1;
        ev.ev_type = mstr_pkg::T_SYN;
        ev.ev_code = mstr_pkg::C_SYN_FRAME;
        ev.last    = 1'b1;
        if (emit_ok) begin
          state_d = mstr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mstr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mstr_pkg::ST_IDLE;
      step_q      <= 3'd0;
      idx_q       <= '0;
      cur_slot_q  <= '0;
      cur_ok_q    <= 1'b1;
      awaiting_q  <= 1'b1;
      down_q      <= '0;
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      cur_slot_q <= cur_slot_d;
      cur_ok_q   <= cur_ok_d;
      awaiting_q <= awaiting_d;
      if (down_set) begin
        down_q[ram_waddr] <= 1'b1;
      end else if (down_clr) begin
        down_q[ram_waddr] <= 1'b0;
      end
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvalid_q <= row_valid_q[ram_raddr];
      end
      if (emit && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= mstr_pkg::opcode_e'(opcode_i);
      type_q  <= event_type_i;
      code_q  <= event_code_i;
      value_q <= event_value_i;
      ix_q    <= inject_x_i;
      iy_q    <= inject_y_i;
    end
    if (emit && emit_ok) begin
      out_q <= ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ev_o    = out_q;

  a_we_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == mstr_pkg::ST_UPD)
    else $error("slot row written outside the update cycle");

  a_read_only_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mstr_pkg::ST_UPD && cfg_i.read_only) |=> state_q == mstr_pkg::ST_IDLE)
    else $error("report started in read-only mode");

  a_finger_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mstr_pkg::ST_FINGER && step_q == 3'd5 && emit_ok)
      |=> state_q == mstr_pkg::ST_SCAN)
    else $error("finger group did not return to scan");

  a_await_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(awaiting_q) |-> $past(state_q) == mstr_pkg::ST_TAIL)
    else $error("first-down flag set outside release tail");

  a_scan_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mstr_pkg::ST_FINGER && $past(state_q) == mstr_pkg::ST_SCAN)
      |-> $past(ram_re))
    else $error("finger emitted without a row read");

endmodule

`default_nettype wire

// ----- hw/rtl/multitouch_slot_tracker_reencoder.sv -----
// Top level of the multitouch slot tracker and re-encoder.
// Holds the configuration registers; depends on mstr_pkg and mstr_ctrl.
//
//   Input channel (in_valid_i / in_stall_o) carries one request: opcode,
//   event type, code, value and injected coordinates. Output channel
//   (out_valid_o / out_stall_i) carries emitted events; last_of_report_o
//   marks the closing sync event of a report.
//   A request that causes no report is accepted with the slot row read,
//   then the row write-back. A report then emits the touch and tool key
//   events on a touch start, scans every slot and emits a group of
//   position, id and sync events per down finger, or the no-finger tail,
//   and ends with the closing event; the slot RAM has a single read port
//   and the output register holds one event.
//   The next request is taken once the report sequencer returns to idle,
//   even while the last event still waits in the output register.
//   When the receiver stalls, the sequencer holds in its next emitting state and the event holds.
//   Reset clears all slot down flags and row valid bits, current slot 0,
//   first-down flag set; configuration returns to zero. Write
//   configuration through cfg_we_i only while the block is idle.
`default_nettype none

module multitouch_slot_tracker_reencoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [2:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [4:0]         event_type_i,
  input  wire logic [9:0]         event_code_i,
  input  wire logic signed [31:0] event_value_i,
  input  wire logic [15:0]        inject_x_i,
  input  wire logic [15:0]        inject_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [4:0]              out_type_o,
  output logic [9:0]              out_code_o,
  output logic signed [31:0]      out_value_o,
  output logic                    last_of_report_o
);

  mstr_pkg::cfg_t   cfg_q;
  mstr_pkg::event_t out_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mstr_pkg::CFG_READ_ONLY:    cfg_q.read_only <= cfg_data_i[0];
        mstr_pkg::CFG_DEVICE_INDEX: cfg_q.dev_index <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mstr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .event_type_i (event_type_i),
    .event_code_i (event_code_i),
    .event_value_i(event_value_i),
    .inject_x_i   (inject_x_i),
    .inject_y_i   (inject_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_ev_o     (out_ev)
  );

  assign out_type_o       = out_ev.ev_type;
  assign out_code_o       = out_ev.ev_code;
  assign out_value_o      = out_ev.ev_value;
  assign last_of_report_o = out_ev.last;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench of multitouch_slot_tracker_reencoder.
// Drives slot-protocol requests and injections, predicts every emitted event and checks
// each one at the output. Depends on mstr_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 100;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_index_i;
  logic [2:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         opcode_i;
  logic [4:0]         event_type_i;
  logic [9:0]         event_code_i;
  logic signed [31:0] event_value_i;
  logic [15:0]        inject_x_i;
  logic [15:0]        inject_y_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [4:0]         out_type_o;
  logic [9:0]         out_code_o;
  logic signed [31:0] out_value_o;
  logic               last_of_report_o;

  multitouch_slot_tracker_reencoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .event_type_i    (event_type_i),
    .event_code_i    (event_code_i),
    .event_value_i   (event_value_i),
    .inject_x_i      (inject_x_i),
    .inject_y_i      (inject_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_type_o      (out_type_o),
    .out_code_o      (out_code_o),
    .out_value_o     (out_value_o),
    .last_of_report_o(last_of_report_o)
  );

  // Predicted slot state and configuration
  logic        finger_down [mstr_pkg::NUM_SLOTS];
  logic [15:0] finger_x    [mstr_pkg::NUM_SLOTS];
  logic [15:0] finger_y    [mstr_pkg::NUM_SLOTS];
  logic [6:0]  finger_id   [mstr_pkg::NUM_SLOTS];
  logic [31:0] active_slot;
  logic        touch_idle;
  logic        ro_mode;
  logic [2:0]  dev_num;

  mstr_pkg::event_t pending_events [$];
  mstr_pkg::event_t want_event;
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_off_start;
  int          hold_off_left;
  int          quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [15:0] clamp_coord(logic signed [31:0] raw);
    if (raw < 0) return 16'd0;
    if (raw > 65535) return 16'hFFFF;
    return raw[15:0];
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'hFFFF;
      2: return 32'd0;
      3: return 32'h0001_0000;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic queue_event(logic [4:0] t, logic [9:0] c, logic [31:0] v, logic l);
    pending_events.insert(pending_events.size(),
                          mstr_pkg::event_t'{ev_type: t, ev_code: c, ev_value: v, last: l});
  endtask

  task automatic predict_report();
    logic any_down;
    any_down = 1'b0;
    if (ro_mode) return;
    for (int s = 0; s < mstr_pkg::NUM_SLOTS; s++) any_down |= finger_down[s];
    if (any_down && touch_idle) begin
      touch_idle = 1'b0;
      queue_event(mstr_pkg::T_KEY, mstr_pkg::C_BTN_TOUCH, 32'd1, 1'b0);
      queue_event(mstr_pkg::T_KEY, mstr_pkg::C_BTN_TOOL_FINGER, 32'd1, 1'b0);
    end
    for (int s = 0; s < mstr_pkg::NUM_SLOTS; s++) begin
      if (finger_down[s]) begin
        queue_event(mstr_pkg::T_ABS, mstr_pkg::C_ABS_X, {16'd0, finger_x[s]}, 1'b0);
        queue_event(mstr_pkg::T_ABS, mstr_pkg::C_ABS_Y, {16'd0, finger_y[s]}, 1'b0);
        queue_event(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, {16'd0, finger_x[s]}, 1'b0);
        queue_event(mstr_pkg::T_ABS, mstr_pkg::C_MT_Y, {16'd0, finger_y[s]}, 1'b0);
        queue_event(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, {25'd0, finger_id[s]}, 1'b0);
        queue_event(mstr_pkg::T_SYN, mstr_pkg::C_SYN_MT_REPORT, 32'd0, 1'b0);
      end
    end
    if (!any_down) begin
      queue_event(mstr_pkg::T_SYN, mstr_pkg::C_SYN_MT_REPORT, 32'd0, 1'b0);
      if (!touch_idle) begin
        touch_idle = 1'b1;
        queue_event(mstr_pkg::T_KEY, mstr_pkg::C_BTN_TOUCH, 32'd0, 1'b0);
        queue_event(mstr_pkg::T_KEY, mstr_pkg::C_BTN_TOOL_FINGER, 32'd0, 1'b0);
      end
    end
    queue_event(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0, 1'b1);
  endtask

  task automatic predict_request(mstr_pkg::opcode_e op, logic [4:0] ev_type,
                                 logic [9:0] ev_code, logic [31:0] ev_value,
                                 logic [15:0] x, logic [15:0] y);
    logic       in_range;
    logic [2:0] dev;
    logic [6:0] slot_id;
    in_range = active_slot < mstr_pkg::NUM_SLOTS;
    dev      = (dev_num > mstr_pkg::DEV_MAX) ? 3'(mstr_pkg::DEV_MAX) : dev_num;
    slot_id  = 7'((2 * dev + 1) * mstr_pkg::ID_STRIDE + active_slot);
    case (op)
      mstr_pkg::OP_RAW: begin
        if (ev_type == mstr_pkg::T_ABS) begin
          if (ev_code == mstr_pkg::C_MT_SLOT) begin
            active_slot = ev_value;
          end else if (in_range && ev_code == mstr_pkg::C_MT_ID) begin
            if (ev_value == mstr_pkg::LIFT_ID) begin
              finger_down[active_slot] = 1'b0;
            end else begin
              finger_id[active_slot]   = slot_id;
              finger_down[active_slot] = 1'b1;
            end
          end else if (in_range && ev_code == mstr_pkg::C_MT_X) begin
            finger_id[active_slot] = slot_id;
            finger_x[active_slot]  = clamp_coord(ev_value);
          end else if (in_range && ev_code == mstr_pkg::C_MT_Y) begin
            finger_id[active_slot] = slot_id;
            finger_y[active_slot]  = clamp_coord(ev_value);
          end
        end else if (ev_type == mstr_pkg::T_SYN && ev_code == mstr_pkg::C_SYN_FRAME) begin
          predict_report();
        end
      end
      mstr_pkg::OP_DOWN: begin
        if (mstr_pkg::INJECT_OK) begin
          finger_id[mstr_pkg::INJECT_SLOT]   = 7'(mstr_pkg::INJECT_TRACK);
          finger_x[mstr_pkg::INJECT_SLOT]    = x;
          finger_y[mstr_pkg::INJECT_SLOT]    = y;
          finger_down[mstr_pkg::INJECT_SLOT] = 1'b1;
        end
        predict_report();
      end
      mstr_pkg::OP_UP: begin
        if (mstr_pkg::INJECT_OK) finger_down[mstr_pkg::INJECT_SLOT] = 1'b0;
        predict_report();
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(mstr_pkg::opcode_e op, logic [4:0] ev_type,
                              logic [9:0] ev_code, logic [31:0] ev_value,
                              logic [15:0] x, logic [15:0] y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    event_type_i  <= ev_type;
    event_code_i  <= ev_code;
    event_value_i <= ev_value;
    inject_x_i    <= x;
    inject_y_i    <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(op, ev_type, ev_code, ev_value, x, y);
  endtask

  task automatic send_raw(logic [4:0] ev_type, logic [9:0] ev_code, logic [31:0] ev_value);
    send_request(mstr_pkg::OP_RAW, ev_type, ev_code, ev_value, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_inject(mstr_pkg::opcode_e op, logic [15:0] x, logic [15:0] y);
    send_request(op, 5'($urandom), 10'($urandom), $urandom, x, y);
  endtask

  // Drop valid, wait out all pending events and the block's own latency
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [0:0] index, logic [2:0] data);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == mstr_pkg::CFG_READ_ONLY) ro_mode = data[0];
    else dev_num = data;
  endtask

  task automatic test_directed_events();
    write_register(mstr_pkg::CFG_DEVICE_INDEX, 3'd0);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'd5);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, 32'hFFFF_FFFB);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_Y, 32'd70000);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd9);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, 32'd65535);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_Y, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'h7FFF_FFFF);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'hFFFF_FFFF);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'd1);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd10);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, 32'd7);
    send_inject(mstr_pkg::OP_DOWN, 16'hFFFF, 16'h0000);
    send_inject(mstr_pkg::OP_UP, 16'h0000, 16'hFFFF);
    send_inject(mstr_pkg::OP_NOP, 16'h1234, 16'h5678);
    send_raw(mstr_pkg::T_KEY, mstr_pkg::C_SYN_FRAME, 32'd0);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_MT_REPORT, 32'd0);
    send_raw(5'd31, 10'd1023, 32'h8000_0000);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, mstr_pkg::LIFT_ID);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
  endtask

  task automatic test_read_only();
    write_register(mstr_pkg::CFG_READ_ONLY, 3'd1);
    write_register(mstr_pkg::CFG_DEVICE_INDEX, 3'd7);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd3);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'd9);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, 32'd100);
    send_inject(mstr_pkg::OP_DOWN, 16'd200, 16'd300);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    write_register(mstr_pkg::CFG_READ_ONLY, 3'd0);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    send_inject(mstr_pkg::OP_UP, 16'd0, 16'd0);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'd3);
    send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, mstr_pkg::LIFT_ID);
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
  endtask

  task automatic test_device_ids();
    for (int d = 0; d < 8; d++) begin
      write_register(mstr_pkg::CFG_DEVICE_INDEX, 3'(d));
      send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'(d));
      send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, 32'(d * 1000));
      send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'd1);
      send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    end
  endtask

  task automatic test_random_traffic(int budget);
    int          sent;
    int          pick;
    logic [31:0] slot_pick;
    sent = 0;
    write_register(mstr_pkg::CFG_DEVICE_INDEX, 3'($urandom_range(0, 7)));
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 3)) begin
          slot_pick = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : $urandom_range(0, mstr_pkg::NUM_SLOTS - 1);
          send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, slot_pick);
          if ($urandom_range(0, 3) == 0) begin
            send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, mstr_pkg::LIFT_ID);
          end else begin
            send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, $urandom);
          end
          send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_X, pick_coord());
          send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_Y, pick_coord());
          sent += 4;
        end
        send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
        sent++;
      end else if (pick < 75) begin
        send_inject(($urandom_range(0, 2) == 0) ? mstr_pkg::OP_UP : mstr_pkg::OP_DOWN,
                    16'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_request(mstr_pkg::opcode_e'($urandom_range(0, 3)), 5'($urandom),
                     10'($urandom), $urandom, 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  // Hold the output off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    for (int s = 0; s < 5; s++) begin
      send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_SLOT, 32'(s));
      send_raw(mstr_pkg::T_ABS, mstr_pkg::C_MT_ID, 32'(s + 1));
    end
    send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    in_valid_i     <= 1'b0;
    hold_off_start <= 1'b1;
    @(posedge clk_i);
    hold_off_start <= 1'b0;
    repeat (12) begin
      send_inject(mstr_pkg::OP_DOWN, 16'($urandom), 16'($urandom));
      send_raw(mstr_pkg::T_SYN, mstr_pkg::C_SYN_FRAME, 32'd0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_off_start) begin
      out_stall_i   <= 1'b1;
      hold_off_left <= HOLD_CYCLES;
    end else if (hold_off_left > 0) begin
      out_stall_i   <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual type %0d code %0d value %0d",
                 $time, out_type_o, out_code_o, out_value_o);
        mismatch_count++;
      end else begin
        want_event = pending_events.pop_front();
        if (out_type_o !== want_event.ev_type) begin
          $display("%0t: out_type expected %0d actual %0d", $time, want_event.ev_type,
                   out_type_o);
          mismatch_count++;
        end
        if (out_code_o !== want_event.ev_code) begin
          $display("%0t: out_code expected %0d actual %0d", $time, want_event.ev_code,
                   out_code_o);
          mismatch_count++;
        end
        if (out_value_o !== want_event.ev_value) begin
          $display("%0t: out_value expected %0d actual %0d", $time, want_event.ev_value,
                   out_value_o);
          mismatch_count++;
        end
        if (last_of_report_o !== want_event.last) begin
          $display("%0t: last_of_report expected %0d actual %0d", $time, want_event.last,
                   last_of_report_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= mstr_pkg::CFG_READ_ONLY;
    cfg_data_i     <= 3'd0;
    in_valid_i     <= 1'b0;
    opcode_i       <= mstr_pkg::OP_NOP;
    event_type_i   <= mstr_pkg::T_SYN;
    event_code_i   <= mstr_pkg::C_SYN_FRAME;
    event_value_i  <= 32'd0;
    inject_x_i     <= 16'd0;
    inject_y_i     <= 16'd0;
    out_stall_i    <= 1'b0;
    quiet_cycles   <= 0;
    hold_off_start <= 1'b0;
    mismatch_count = 0;
    for (int s = 0; s < mstr_pkg::NUM_SLOTS; s++) begin
      finger_down[s] = 1'b0;
      finger_x[s]    = 16'd0;
      finger_y[s]    = 16'd0;
      finger_id[s]   = 7'd0;
    end
    active_slot = 32'd0;
    touch_idle  = 1'b1;
    ro_mode     = 1'b0;
    dev_num     = 3'd0;
    send_idle_pct = 22;
    recv_idle_pct = 56;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_events();
    test_read_only();
    test_device_ids();
    test_random_traffic(55);
    send_idle_pct = 56;
    recv_idle_pct = 22;
    test_random_traffic(55);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(55);

    wait_drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
